// ===== hdl/diagonal_glow_stencil_core_defines.svh =====
// Assertion macros shared by the diagonal glow stencil RTL.
`ifndef DIAGONAL_GLOW_STENCIL_CORE_DEFINES_SVH
`define DIAGONAL_GLOW_STENCIL_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DGS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("diagonal glow stencil: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("diagonal glow stencil: next-cycle check failed");

`endif

// ===== hdl/dgs_pkg.sv =====
// Shared types, constants and arithmetic helpers of the diagonal glow stencil.
`default_nettype none
package dgs_pkg;

	localparam int MAX_DIM = 1024;
	localparam int COL_W = $clog2(MAX_DIM);
	localparam int DIM_W = 11;
	localparam int CH_W = 16;

	localparam logic [DIM_W-1:0] SIZE_RESET = DIM_W'(64);
	localparam logic [DIM_W-1:0] SIZE_MAX = DIM_W'(MAX_DIM);

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_PAD = 1'b1;

	// floor(3c/10) = (c * 3 * ceil(2^21/10)) >> 21, exact for every 16-bit c.
	// floor(4n/25) = (n * ceil(2^23/25)) >> 21, exact for every 16-bit n.
	localparam int MUL_W = 20;
	localparam int MUL_SHIFT = 21;
	localparam logic [MUL_W-1:0] CTR_MUL = MUL_W'(629148);
	localparam logic [MUL_W-1:0] DIAG_MUL = MUL_W'(335545);

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} dgs_pix_t;

	typedef struct packed {
		dgs_pix_t mid;
		dgs_pix_t top;
	} dgs_line_t;

	typedef struct packed {
		logic up;
		logic down;
		logic left;
		logic right;
	} dgs_edge_t;

	typedef struct packed {
		logic [CH_W-1:0] ctr;
		logic [CH_W-1:0] ul;
		logic [CH_W-1:0] ur;
		logic [CH_W-1:0] dl;
		logic [CH_W-1:0] dr;
	} dgs_terms_t;

	function automatic logic [CH_W-1:0] pix_chan(dgs_pix_t p, int k);
		logic [CH_W-1:0] c;
		case (k)
			0: c = p.red;
			1: c = p.green;
			default: c = p.blue;
		endcase
		return c;
	endfunction

	function automatic logic [CH_W-1:0] scale_term(logic [CH_W-1:0] c, logic [MUL_W-1:0] m);
		logic [CH_W+MUL_W-1:0] p;
		p = (CH_W+MUL_W)'(c) * (CH_W+MUL_W)'(m);
		return p[MUL_SHIFT +: CH_W];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/dgs_in_if.sv =====
// Input channel of the stencil: one pixel or pad item per handshake.
`default_nettype none
interface dgs_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] in_red;
	logic [15:0] in_green;
	logic [15:0] in_blue;

	modport source(output valid, operation, in_red, in_green, in_blue, input ready);
	modport sink(input valid, operation, in_red, in_green, in_blue, output ready);
endinterface
`default_nettype wire

// ===== hdl/dgs_out_if.sv =====
// Output channel of the stencil: one glowed pixel per handshake.
`default_nettype none
interface dgs_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_red;
	logic [15:0] out_green;
	logic [15:0] out_blue;
	logic        frame_last;

	modport source(output valid, out_red, out_green, out_blue, frame_last, input ready);
	modport sink(input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/diagonal_glow_stencil_core.sv =====
// Top level of the diagonal glow stencil: position tracking, window and pipeline.
`default_nettype none
`include "diagonal_glow_stencil_core_defines.svh"

// Streaming 3x3 diagonal glow over a square image of image_size x image_size
// 16-bit RGB pixels sent in raster order. The block takes one item every
// clock cycle while the output is not stalled. The result for a centre pixel
// is released when the item one row plus one pixel after it is accepted: its
// terms are loaded into the term register at that same clock edge, and it
// then reaches the output through the output register. A stalled output holds
// the whole pipeline and the input. After the
// last pixel of a frame the sender gives image_size+1 pad items to drain
// the window; the result with frame_last set ends the frame. Two line
// buffers of 1024 pixels share one memory with one write and one registered
// read port per cycle; it needs no clearing after reset. Writing image_size
// (0 is taken as 1, values above 1024 as 1024) restarts the frame; the user
// must do it only while no item is in flight, as the block does not check.
module diagonal_glow_stencil_core
	import dgs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [DIM_W-1:0] cfg_data,
	dgs_in_if.sink                in_ch,
	dgs_out_if.source             out_ch
);

	logic [DIM_W-1:0] dim_q;
	logic [DIM_W-1:0] in_row_q;
	logic [DIM_W-1:0] in_col_q;
	logic [DIM_W-1:0] out_row_q;
	logic [DIM_W-1:0] out_col_q;
	dgs_pix_t         w0_q, w1_q, w2_q, w4_q, w5_q;

	logic             en;
	logic             acc;
	logic             cfg_wr;
	logic             primed;
	logic             produce;
	logic             last;
	logic             frame_done;
	logic             pos_zero;
	dgs_edge_t        edges;
	dgs_pix_t         cur;
	dgs_line_t        rd_line;
	dgs_line_t        wr_line;
	logic [DIM_W-1:0] dim_m1;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] nxt_col;
	logic [DIM_W-1:0] size_clamped;

	logic             valid_s1;
	logic             last_s1;
	dgs_terms_t [2:0] terms_s1;
	logic             out_valid_q;
	logic             out_last_q;
	dgs_pix_t         out_pix_q;

	assign en = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;
	assign acc = in_ch.valid && en;
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid;

	assign cur = (in_ch.operation == OP_PAD) ? '0 :
		dgs_pix_t'{blue: in_ch.in_blue, green: in_ch.in_green, red: in_ch.in_red};

	// A result is due once the input index reaches dim+1.
	assign primed = (in_row_q > DIM_W'(1)) || ((in_row_q == DIM_W'(1)) && (in_col_q != '0));
	assign produce = acc && primed;

	assign dim_m1 = dim_q - DIM_W'(1);
	assign edges.up = (out_row_q != '0);
	assign edges.down = (out_row_q != dim_m1);
	assign edges.left = (out_col_q != '0);
	assign edges.right = (out_col_q != dim_m1);
	assign last = (out_row_q == dim_m1) && (out_col_q == dim_m1);
	assign frame_done = produce && last;

	assign pos_zero = (in_row_q == '0) && (in_col_q == '0)
		&& (out_row_q == '0) && (out_col_q == '0);

	assign col_inc = in_col_q + DIM_W'(1);

	always_comb begin
		if (cfg_wr || frame_done) begin
			nxt_col = '0;
		end else if (acc) begin
			nxt_col = (col_inc >= dim_q) ? '0 : col_inc;
		end else begin
			nxt_col = in_col_q;
		end
	end

	always_comb begin
		if (cfg_data == '0) begin
			size_clamped = DIM_W'(1);
		end else if (cfg_data > SIZE_MAX) begin
			size_clamped = SIZE_MAX;
		end else begin
			size_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= SIZE_RESET;
			in_row_q <= '0;
			in_col_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_wr) begin
			dim_q <= size_clamped;
			in_row_q <= '0;
			in_col_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (frame_done) begin
			in_row_q <= '0;
			in_col_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (acc) begin
			in_col_q <= nxt_col;
			if (col_inc >= dim_q) begin
				in_row_q <= in_row_q + DIM_W'(1);
			end
			if (produce) begin
				if (out_col_q == dim_m1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + DIM_W'(1);
				end else begin
					out_col_q <= out_col_q + DIM_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0;
			w1_q <= '0;
			w2_q <= '0;
			w4_q <= '0;
			w5_q <= '0;
		end else if (acc) begin
			w1_q <= w0_q;
			w0_q <= rd_line.top;
			w2_q <= rd_line.mid;
			w5_q <= w4_q;
			w4_q <= cur;
		end
	end

	assign wr_line.mid = cur;
	assign wr_line.top = rd_line.mid;

	dgs_line_store u_line_store (
		.clk     (clk),
		.wr_en   (acc),
		.wr_addr (COL_W'(in_col_q)),
		.wr_data (wr_line),
		.rd_addr (COL_W'(nxt_col)),
		.rd_data (rd_line)
	);

	dgs_term_stage u_term_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.produce    (produce),
		.last       (last),
		.edges      (edges),
		.centre     (w2_q),
		.up_left    (w1_q),
		.up_right   (rd_line.top),
		.down_left  (w5_q),
		.down_right (cur),
		.valid_s1   (valid_s1),
		.last_s1    (last_s1),
		.terms_s1   (terms_s1)
	);

	dgs_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.last_s1  (last_s1),
		.terms_s1 (terms_s1),
		.valid_q  (out_valid_q),
		.last_q   (out_last_q),
		.pix_q    (out_pix_q)
	);

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_red = out_pix_q.red;
	assign out_ch.out_green = out_pix_q.green;
	assign out_ch.out_blue = out_pix_q.blue;
	assign out_ch.frame_last = out_last_q;

	`DGS_ASSERT_SAME(a_in_col_range, clk, arst_n, 1'b1, in_col_q < dim_q)
	`DGS_ASSERT_SAME(a_out_pos_range, clk, arst_n, 1'b1, (out_row_q < dim_q) && (out_col_q < dim_q))
	`DGS_ASSERT_NEXT(a_frame_restart, clk, arst_n, frame_done, pos_zero)

endmodule
`default_nettype wire

// ===== hdl/dgs_line_store.sv =====
// Two line buffers kept side by side in one memory with a registered read port.
`default_nettype none
module dgs_line_store
	import dgs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [COL_W-1:0] wr_addr,
	input  wire dgs_line_t        wr_data,
	input  wire logic [COL_W-1:0] rd_addr,
	output dgs_line_t             rd_data
);

	dgs_line_t mem [MAX_DIM];
	dgs_line_t rd_q;

	// The read is made ahead for the column of the next item, so a
	// write to that same column in this cycle is forwarded.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

// ===== hdl/dgs_term_stage.sv =====
// First pipeline stage: the five weighted terms of each channel, registered.
`default_nettype none
module dgs_term_stage
	import dgs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       produce,
	input  wire logic       last,
	input  wire dgs_edge_t  edges,
	input  wire dgs_pix_t   centre,
	input  wire dgs_pix_t   up_left,
	input  wire dgs_pix_t   up_right,
	input  wire dgs_pix_t   down_left,
	input  wire dgs_pix_t   down_right,
	output logic            valid_s1,
	output logic            last_s1,
	output dgs_terms_t [2:0] terms_s1
);

	dgs_terms_t [2:0] terms;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			terms[k].ctr = scale_term(pix_chan(centre, k), CTR_MUL);
			terms[k].ul = (edges.up && edges.left) ?
				scale_term(pix_chan(up_left, k), DIAG_MUL) : '0;
			terms[k].ur = (edges.up && edges.right) ?
				scale_term(pix_chan(up_right, k), DIAG_MUL) : '0;
			terms[k].dl = (edges.down && edges.left) ?
				scale_term(pix_chan(down_left, k), DIAG_MUL) : '0;
			terms[k].dr = (edges.down && edges.right) ?
				scale_term(pix_chan(down_right, k), DIAG_MUL) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= last;
			terms_s1 <= terms;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/dgs_out_stage.sv =====
// Second pipeline stage: sums the terms into the output register.
`default_nettype none
module dgs_out_stage
	import dgs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             valid_s1,
	input  wire logic             last_s1,
	input  wire dgs_terms_t [2:0] terms_s1,
	output logic                  valid_q,
	output logic                  last_q,
	output dgs_pix_t              pix_q
);

	logic [2:0][CH_W+2:0] sums;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sums[k] = (CH_W+3)'(terms_s1[k].ctr) + (CH_W+3)'(terms_s1[k].ul)
				+ (CH_W+3)'(terms_s1[k].ur) + (CH_W+3)'(terms_s1[k].dl)
				+ (CH_W+3)'(terms_s1[k].dr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s1;
		end
	end

	// The sum never exceeds 16 bits, so the low bits are the whole value.
	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= last_s1;
			pix_q.red <= sums[0][CH_W-1:0];
			pix_q.green <= sums[1][CH_W-1:0];
			pix_q.blue <= sums[2][CH_W-1:0];
		end
	end

endmodule
`default_nettype wire
